>>> sv/pps_pkg.sv
// Package: shared types and constants for the sequential PPS sample selector.
`default_nettype none

package pps_pkg;

  localparam int unsigned FRAC_W = 32;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned CNT_W  = 17;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // One unit as it travels from the front queue to the decision stage
  typedef struct packed {
    logic [FRAC_W-1:0] frac_prob;
    logic [FRAC_W-1:0] uniform_draw;
    logic [IDX_W-1:0]  unit_index;
    logic              first_unit;
    logic              last_unit;
    logic              zero_prob;
  } pps_item_t;

endpackage

`default_nettype wire

>>> sv/pps_front.sv
// Front end: accepts unit transactions, tags them and holds them in a short queue.
`default_nettype none

module pps_front
  import pps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FRAC_W-1:0] in_frac_prob,
  input  wire logic [FRAC_W-1:0] in_uniform_draw,
  input  wire logic [IDX_W-1:0]  in_unit_index,
  input  wire logic              in_first_unit,
  input  wire logic              in_last_unit,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output pps_item_t              q_item
);

  // Depth must be a power of two so the pointers wrap on their own
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);

  pps_item_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  fill_r, fill_nxt;
  pps_item_t          new_item;
  logic               push, pop;

  // Classify the incoming unit
  always_comb begin
    new_item.frac_prob    = in_frac_prob;
    new_item.uniform_draw = in_uniform_draw;
    new_item.unit_index   = in_unit_index;
    new_item.first_unit   = in_first_unit;
    new_item.last_unit    = in_last_unit;
    new_item.zero_prob    = (in_frac_prob == '0);
  end

  assign in_ready = (fill_r != DEPTH_C);
  assign q_valid  = (fill_r != '0);
  assign q_item   = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

>>> sv/pps_back.sv
// Back end: cumulative state, Chromy selection decision and output register.
`default_nettype none

module pps_back
  import pps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire pps_item_t        q_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_chosen,
  output logic [IDX_W-1:0]      out_chosen_index,
  output logic [CNT_W-1:0]      out_count_so_far,
  output logic                  out_run_end
);

  logic [CNT_W-1:0]    target_r;
  logic [CNT_W-1:0]    cum_integer_r, cum_integer_nxt;
  logic [FRAC_W-1:0]   cum_fraction_r, cum_fraction_nxt;
  logic [CNT_W-1:0]    selected_total_r, selected_total_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_chosen_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [CNT_W-1:0]    out_count_r;
  logic                out_end_r;

  logic [FRAC_W-1:0]   fp, fc;
  logic [CNT_W-1:0]    ip, tot;
  logic [FRAC_W:0]     sum;
  logic                crossing;
  logic [2*FRAC_W-1:0] prod;
  logic [2*FRAC_W-1:0] rest;
  logic                below_nc, below_cr, pick;
  logic                load;

  assign q_ready = !out_valid_r || out_ready;
  assign load    = q_valid && q_ready;

  // Start of a run clears the running state
  always_comb begin
    fp  = q_item.first_unit ? '0 : cum_fraction_r;
    ip  = q_item.first_unit ? '0 : cum_integer_r;
    tot = q_item.first_unit ? '0 : selected_total_r;
  end

  // Cumulative add and the single u*Fp product
  always_comb begin
    sum      = {1'b0, fp} + {1'b0, q_item.frac_prob};
    crossing = sum[FRAC_W];
    fc       = sum[FRAC_W-1:0];
    prod     = {{FRAC_W{1'b0}}, q_item.uniform_draw} * {{FRAC_W{1'b0}}, fp};
    // u*(1-Fp) never goes negative, so rest fits the product width
    rest     = {q_item.uniform_draw, {FRAC_W{1'b0}}} - prod;
    below_nc = !q_item.zero_prob && (rest < {q_item.frac_prob, {FRAC_W{1'b0}}});
    below_cr = prod < {fc, {FRAC_W{1'b0}}};
  end

  // Selection rule
  always_comb begin
    if (!crossing) begin
      pick = (tot == ip) && below_nc;
    end else if (tot == ip) begin
      pick = 1'b1;
    end else begin
      pick = (fp != '0) && below_cr;
    end
    if (target_r == '0) begin
      pick = 1'b0;
    end
  end

  // State update with saturating counters
  always_comb begin
    cum_integer_nxt    = cum_integer_r;
    cum_fraction_nxt   = cum_fraction_r;
    selected_total_nxt = selected_total_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    if (load) begin
      selected_total_nxt = (pick && tot != CNT_MAX) ? tot + 1'b1 : tot;
      cum_integer_nxt    = (crossing && ip != CNT_MAX) ? ip + 1'b1 : ip;
      cum_fraction_nxt   = fc;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r         <= '0;
      cum_integer_r    <= '0;
      cum_fraction_r   <= '0;
      selected_total_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      cum_integer_r    <= cum_integer_nxt;
      cum_fraction_r   <= cum_fraction_nxt;
      selected_total_r <= selected_total_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_chosen_r <= pick;
      out_index_r  <= q_item.unit_index;
      out_count_r  <= selected_total_nxt;
      out_end_r    <= q_item.last_unit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen       = out_chosen_r;
  assign out_chosen_index = out_index_r;
  assign out_count_so_far = out_count_r;
  assign out_run_end      = out_end_r;

  // Checks
  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    load && (target_r == '0) |=> !out_chosen_r)
    else $error("unit chosen with zero target");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_count_r == selected_total_r) && out_valid_r)
    else $error("reported count differs from running total");

  a_chosen_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_chosen_r |-> out_count_r != '0)
    else $error("chosen unit with zero count");

  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    load && q_item.first_unit |=> out_count_r <= CNT_W'(1))
    else $error("first unit of run counted more than one selection");

endmodule

`default_nettype wire

>>> sv/sequential_pps_sample_selector.sv
// Top level: sequential PPS sample selector, queue front end and decision back end.
// Path: a unit written into the queue waits there until the back end takes it, is decided and
//   its result is held on the output from then on (queue then output register).
// Throughput: one unit per cycle while out_ready keeps the output free, set by the state loop
//   through the u*Fp multiply and its compares in the decision stage.
// The input side keeps accepting while a result waits, until the queue is full.
// Reset (rst_n low, synchronous): clears queue, cumulative state, target and output valid.
`default_nettype none

module sequential_pps_sample_selector
  import pps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [FRAC_W-1:0] in_frac_prob,
  input  wire logic [FRAC_W-1:0] in_uniform_draw,
  input  wire logic [IDX_W-1:0]  in_unit_index,
  input  wire logic              in_first_unit,
  input  wire logic              in_last_unit,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_chosen,
  output logic [IDX_W-1:0]       out_chosen_index,
  output logic [CNT_W-1:0]       out_count_so_far,
  output logic                   out_run_end
);

  logic      q_valid, q_ready;
  pps_item_t q_item;

  pps_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_frac_prob   (in_frac_prob),
    .in_uniform_draw(in_uniform_draw),
    .in_unit_index  (in_unit_index),
    .in_first_unit  (in_first_unit),
    .in_last_unit   (in_last_unit),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item)
  );

  pps_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_chosen      (out_chosen),
    .out_chosen_index(out_chosen_index),
    .out_count_so_far(out_count_so_far),
    .out_run_end     (out_run_end)
  );

endmodule

`default_nettype wire
